// File: hw/rtl/fixed_length_path_search_top_assert.svh
// Assertion macros for the fixed-length path search block.
`ifndef FIXED_LENGTH_PATH_SEARCH_TOP_ASSERT_SVH
`define FIXED_LENGTH_PATH_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPS_ASSERT_IMP(lbl, ante, cons, msg)
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fps_pkg.sv
// Shared constants for the fixed-length path search block.
`default_nettype none

package fps_pkg;

  localparam int OP_W        = 2;
  localparam int VERTEX_W    = 5;
  localparam int SLOT_W      = 4;
  localparam int DEGREE_W    = 5;
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 6;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_DEGREE   = 16;
  localparam int STACK_DEPTH  = 32;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(32);

  localparam logic [OP_W-1:0] OP_WR_NBR = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_DEG = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/fps_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none

module fps_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/fixed_length_path_search_top.sv
// Top level of the fixed-length path search: graph load, search sequencer, result output.
//
//   channel  | signals                                  | transfer when
//   ---------+------------------------------------------+----------------------------
//   command  | start, busy, in_op .. in_path_length     | start high while busy low
//   result   | out_valid, out_found, out_path_vertex,   | every cycle out_valid is high
//            | out_last                                 |
//   config   | cfg_valid, cfg_ready, cfg_vertex_count   | cfg_valid and cfg_ready high
//
// Graph writes never leave idle. A rejected query is answered in the cycle after it is
// accepted. A search tries neighbour slots, backtracks, and at full length scans the
// candidate's slots for the end vertex; all of it is paced by the single read port of the
// neighbour RAM. A found path is then streamed from the start vertex to the end vertex.
// Reset is synchronous and clears the degree table and used marks at once; there is no
// clearing pass. Results cannot be stalled.
`default_nettype none

`include "fixed_length_path_search_top_assert.svh"

module fixed_length_path_search_top #(
  parameter int MaxVertices = fps_pkg::MAX_VERTICES,
  parameter int MaxDegree   = fps_pkg::MAX_DEGREE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fps_pkg::OP_W-1:0]      in_op,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_vertex,
  input  wire logic [fps_pkg::SLOT_W-1:0]    in_slot,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_neighbour,
  input  wire logic [fps_pkg::DEGREE_W-1:0]  in_degree,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_start_vertex,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_end_vertex,
  input  wire logic [fps_pkg::LEN_W-1:0]     in_path_length,
  output logic                               out_valid,
  output logic                               out_found,
  output logic      [fps_pkg::VERTEX_W-1:0]  out_path_vertex,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fps_pkg::CFG_W-1:0]     cfg_vertex_count
);

  import fps_pkg::*;

  // Vertex fields are five bits wide, so rows beyond that can never be addressed.
  localparam int NumRows  = (MaxVertices < (1 << VERTEX_W)) ? MaxVertices : (1 << VERTEX_W);
  localparam int RowW     = $clog2(NumRows);
  localparam int SlotW    = $clog2(MaxDegree);
  localparam int DegW     = $clog2(MaxDegree + 1);
  localparam int NbrDepth = NumRows << SlotW;
  localparam int NbrAw    = RowW + SlotW;
  localparam int StackAw  = $clog2(STACK_DEPTH);
  localparam int StackW   = VERTEX_W + DegW;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FETCH     = 4'd1;
  localparam logic [3:0] S_POP       = 4'd2;
  localparam logic [3:0] S_TEST      = 4'd3;
  localparam logic [3:0] S_TOUCH     = 4'd4;
  localparam logic [3:0] S_TOUCH_CHK = 4'd5;
  localparam logic [3:0] S_EMIT_A    = 4'd6;
  localparam logic [3:0] S_EMIT_B    = 4'd7;
  localparam logic [3:0] S_EMIT_K    = 4'd8;
  localparam logic [3:0] S_EMIT_E    = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    vc_r, vc_nxt;
  logic [CFG_W-1:0]    cnt_r, cnt_nxt;
  logic [VERTEX_W-1:0] u_r, u_nxt;
  logic [VERTEX_W-1:0] k_r, k_nxt;
  logic [VERTEX_W-1:0] end_r, end_nxt;
  logic [DegW-1:0]     j_r, j_nxt;
  logic [DegW-1:0]     t_r, t_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    i_r, i_nxt;
  logic [NumRows-1:0]  used_r, used_nxt;
  logic [DegW-1:0]     deg_r [NumRows];

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [VERTEX_W-1:0] out_path_vertex_r, out_path_vertex_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic [CFG_W-1:0]    live;
  logic                bad_query;
  logic [VERTEX_W-1:0] deg_addr;
  logic [DegW-1:0]     deg_cur;
  logic                k_ok;
  logic                k_skip;

  logic                nbr_we;
  logic [NbrAw-1:0]    nbr_waddr;
  logic [NbrAw-1:0]    nbr_raddr;
  logic [VERTEX_W-1:0] nbr_rdata;

  logic                stk_we;
  logic [StackAw-1:0]  stk_waddr;
  logic [StackAw-1:0]  stk_raddr;
  logic [StackW-1:0]   stk_wdata;
  logic [StackW-1:0]   stk_rdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_path_vertex = out_path_vertex_r;
  assign out_last        = out_last_r;

  assign live = (vc_r > CFG_W'(NumRows)) ? CFG_W'(NumRows) : vc_r;
  assign bad_query = (CFG_W'(in_start_vertex) >= live) || (CFG_W'(in_end_vertex) >= live) ||
                     (in_start_vertex == in_end_vertex) || (in_path_length < LEN_W'(2));

  // The degree lookup serves the current vertex, or the candidate during the end check.
  assign deg_addr = (state_r == S_TOUCH) ? k_r : u_r;
  assign deg_cur  = deg_r[RowW'(deg_addr)];

  // A neighbour outside the live graph is treated exactly like a used one.
  assign k_ok   = (CFG_W'(nbr_rdata) < cnt_r);
  assign k_skip = !k_ok || used_r[RowW'(nbr_rdata)];

  // Neighbour RAM: loaded in idle, read only while searching, so ports never collide.
  assign nbr_we    = accept && (in_op == OP_WR_NBR) && (int'(in_vertex) < NumRows) &&
                     (int'(in_slot) < MaxDegree);
  assign nbr_waddr = {RowW'(in_vertex), SlotW'(in_slot)};
  assign nbr_raddr = (state_r == S_TOUCH) ? {RowW'(k_r), SlotW'(t_r)}
                                          : {RowW'(u_r), SlotW'(j_r)};

  fps_ram #(
    .Width (VERTEX_W),
    .Depth (NbrDepth)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (in_neighbour),
    .raddr (nbr_raddr),
    .rdata (nbr_rdata)
  );

  // Stack entry d holds path vertex d and the slot to resume at for depth d + 1.
  // Writes and reads fall in different states, so no forwarding is needed.
  assign stk_waddr = StackAw'(pos_r - LEN_W'(2));
  assign stk_wdata = {u_r, j_r};
  always_comb begin
    case (state_r)
      S_FETCH:  stk_raddr = StackAw'(pos_r - LEN_W'(3));
      S_EMIT_B: stk_raddr = StackAw'(i_r + LEN_W'(1));
      default:  stk_raddr = StackAw'(i_r);
    endcase
  end

  fps_ram #(
    .Width (StackW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt           = state_r;
    vc_nxt              = vc_r;
    cnt_nxt             = cnt_r;
    u_nxt               = u_r;
    k_nxt               = k_r;
    end_nxt             = end_r;
    j_nxt               = j_r;
    t_nxt               = t_r;
    pos_nxt             = pos_r;
    len_nxt             = len_r;
    i_nxt               = i_r;
    used_nxt            = used_r;
    out_valid_nxt       = 1'b0;
    out_found_nxt       = 1'b0;
    out_path_vertex_nxt = '0;
    out_last_nxt        = 1'b0;
    stk_we              = 1'b0;

    if (cfg_valid && cfg_ready) begin
      vc_nxt = cfg_vertex_count;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_QUERY)) begin
          if (bad_query) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end else begin
            used_nxt                        = '0;
            used_nxt[RowW'(in_start_vertex)] = 1'b1;
            used_nxt[RowW'(in_end_vertex)]   = 1'b1;
            cnt_nxt   = live;
            u_nxt     = in_start_vertex;
            end_nxt   = in_end_vertex;
            len_nxt   = in_path_length;
            pos_nxt   = LEN_W'(2);
            j_nxt     = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (j_r >= deg_cur) begin
          if (pos_r <= LEN_W'(2)) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            used_nxt[RowW'(u_r)] = 1'b0;
            pos_nxt   = pos_r - LEN_W'(1);
            state_nxt = S_POP;
          end
        end else begin
          j_nxt     = j_r + DegW'(1);
          state_nxt = S_TEST;
        end
      end
      S_POP: begin
        u_nxt     = stk_rdata[StackW-1 -: VERTEX_W];
        j_nxt     = stk_rdata[DegW-1:0];
        state_nxt = S_FETCH;
      end
      S_TEST: begin
        if (k_skip) begin
          state_nxt = S_FETCH;
        end else if (pos_r < len_r) begin
          used_nxt[RowW'(nbr_rdata)] = 1'b1;
          stk_we    = 1'b1;
          u_nxt     = nbr_rdata;
          pos_nxt   = pos_r + LEN_W'(1);
          j_nxt     = '0;
          state_nxt = S_FETCH;
        end else begin
          k_nxt     = nbr_rdata;
          t_nxt     = '0;
          state_nxt = S_TOUCH;
        end
      end
      S_TOUCH: begin
        if (t_r >= deg_cur) begin
          state_nxt = S_FETCH;
        end else begin
          t_nxt     = t_r + DegW'(1);
          state_nxt = S_TOUCH_CHK;
        end
      end
      S_TOUCH_CHK: begin
        if (nbr_rdata == end_r) begin
          // Store the last stacked vertex so the whole prefix streams from the RAM.
          stk_we    = 1'b1;
          i_nxt     = '0;
          state_nxt = S_EMIT_A;
        end else begin
          state_nxt = S_TOUCH;
        end
      end
      S_EMIT_A: begin
        state_nxt = S_EMIT_B;
      end
      S_EMIT_B: begin
        out_valid_nxt       = 1'b1;
        out_found_nxt       = 1'b1;
        out_path_vertex_nxt = stk_rdata[StackW-1 -: VERTEX_W];
        if (i_r == pos_r - LEN_W'(2)) begin
          state_nxt = S_EMIT_K;
        end else begin
          i_nxt = i_r + LEN_W'(1);
        end
      end
      S_EMIT_K: begin
        out_valid_nxt       = 1'b1;
        out_found_nxt       = 1'b1;
        out_path_vertex_nxt = k_r;
        state_nxt           = S_EMIT_E;
      end
      S_EMIT_E: begin
        out_valid_nxt       = 1'b1;
        out_found_nxt       = 1'b1;
        out_path_vertex_nxt = end_r;
        out_last_nxt        = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= VCOUNT_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r             <= cnt_nxt;
    u_r               <= u_nxt;
    k_r               <= k_nxt;
    end_r             <= end_nxt;
    j_r               <= j_nxt;
    t_r               <= t_nxt;
    pos_r             <= pos_nxt;
    len_r             <= len_nxt;
    i_r               <= i_nxt;
    out_found_r       <= out_found_nxt;
    out_path_vertex_r <= out_path_vertex_nxt;
    out_last_r        <= out_last_nxt;
  end

  // Degree table, cleared by reset; a degree above the slot count is clipped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NumRows; r++) begin
        deg_r[r] <= '0;
      end
    end else if (accept && (in_op == OP_WR_DEG) && (int'(in_vertex) < NumRows)) begin
      deg_r[RowW'(in_vertex)] <= (int'(in_degree) > MaxDegree) ? DegW'(MaxDegree)
                                                                : DegW'(in_degree);
    end
  end

  `FPS_ASSERT_IMP(a_notfound_form, out_valid_r && !out_found_r,
                  out_last_r && (out_path_vertex_r == '0), "not-found result malformed")
  `FPS_ASSERT_IMP(a_depth_range, state_r != S_IDLE,
                  (pos_r >= LEN_W'(2)) && (pos_r <= len_r), "search depth out of range")
  `FPS_ASSERT_IMP(a_end_marked, state_r != S_IDLE,
                  used_r[RowW'(end_r)], "end vertex lost its used mark")
  `FPS_ASSERT_NEXT(a_no_early_result, state_r == S_TEST,
                   !out_valid_r, "result strobe while a candidate is tested")

endmodule

`default_nettype wire

// File: tb/fixed_length_path_search_checker.sv
// Checker for the fixed-length path search: predicts every query's path and compares results.
module fixed_length_path_search_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [fps_pkg::OP_W-1:0]      in_op,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_vertex,
  input  wire logic [fps_pkg::SLOT_W-1:0]    in_slot,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_neighbour,
  input  wire logic [fps_pkg::DEGREE_W-1:0]  in_degree,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_start_vertex,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  in_end_vertex,
  input  wire logic [fps_pkg::LEN_W-1:0]     in_path_length,
  input  wire logic                          out_valid,
  input  wire logic                          out_found,
  input  wire logic [fps_pkg::VERTEX_W-1:0]  out_path_vertex,
  input  wire logic                          out_last,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [fps_pkg::CFG_W-1:0]     cfg_vertex_count,
  output int                                 error_count,
  output int                                 outstanding
);
  import fps_pkg::*;

  typedef struct packed {
    logic                found;
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } path_result_t;

  logic [VERTEX_W-1:0] adjacency [MAX_VERTICES*MAX_DEGREE];
  logic [DEGREE_W-1:0] degree_of [MAX_VERTICES];
  logic [CFG_W-1:0]    vertex_count;
  path_result_t        expected_path [$];
  int                  mismatches = 0;

  // Depth-first search for a simple path of exactly len edges; the end vertex is
  // marked from the start, so it can only appear as the final hop.
  function automatic void predict_path(input logic [VERTEX_W-1:0] src,
                                       input logic [VERTEX_W-1:0] dst,
                                       input logic [LEN_W-1:0]    len);
    logic [VERTEX_W-1:0] trail [STACK_DEPTH];
    int                  resume [STACK_DEPTH];
    bit                  on_path [MAX_VERTICES];
    int                  live, depth, next_slot, cur, nxt, i;
    bit                  reaches;
    live = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    if (src >= live || dst >= live || src == dst || len < 2) begin
      expected_path.push_back(path_result_t'{1'b0, '0, 1'b1});
      return;
    end
    for (i = 0; i < MAX_VERTICES; i++) on_path[i] = 1'b0;
    on_path[src] = 1'b1;
    on_path[dst] = 1'b1;
    trail[0] = src;
    depth = 2;
    next_slot = 0;
    while (1) begin
      cur = trail[depth-2];
      if (next_slot >= degree_of[cur]) begin
        depth--;
        if (depth < 2) break;
        on_path[trail[depth-1]] = 1'b0;
        next_slot = resume[depth-1];
        continue;
      end
      nxt = adjacency[cur*MAX_DEGREE + next_slot];
      next_slot++;
      // Vertices beyond the live count are skipped just like used ones.
      if (nxt >= live || on_path[nxt]) continue;
      if (depth < len) begin
        on_path[nxt] = 1'b1;
        trail[depth-1] = VERTEX_W'(nxt);
        resume[depth-1] = next_slot;
        depth++;
        next_slot = 0;
        continue;
      end
      reaches = 1'b0;
      for (i = 0; i < degree_of[nxt]; i++) begin
        if (adjacency[nxt*MAX_DEGREE + i] == dst) reaches = 1'b1;
      end
      if (reaches) begin
        trail[depth-1] = VERTEX_W'(nxt);
        for (i = 0; i < depth; i++) expected_path.push_back(path_result_t'{1'b1, trail[i], 1'b0});
        expected_path.push_back(path_result_t'{1'b1, dst, 1'b1});
        return;
      end
    end
    expected_path.push_back(path_result_t'{1'b0, '0, 1'b1});
  endfunction

  always @(posedge clk) begin
    path_result_t want;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < MAX_VERTICES*MAX_DEGREE; i++) adjacency[i] = '0;
      for (i = 0; i < MAX_VERTICES; i++) degree_of[i] = '0;
      vertex_count = VCOUNT_RESET;
      expected_path.delete();
    end else begin
      // A result at this edge always belongs to a command accepted at an earlier edge.
      if (out_valid) begin
        if (expected_path.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0d vertex=%0d last=%0d",
                     out_found, out_path_vertex, out_last);
        end else begin
          want = expected_path.pop_front();
          if (want.found !== out_found || want.vertex !== out_path_vertex ||
              want.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected found=%0d vertex=%0d last=%0d,",
                       want.found, want.vertex, want.last,
                       " got found=%0d vertex=%0d last=%0d",
                       out_found, out_path_vertex, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) vertex_count = cfg_vertex_count;
      if (start && !busy) begin
        case (in_op)
          OP_WR_NBR: adjacency[in_vertex*MAX_DEGREE + in_slot] = in_neighbour;
          OP_WR_DEG: degree_of[in_vertex] = (in_degree > MAX_DEGREE) ?
                                            DEGREE_W'(MAX_DEGREE) : in_degree;
          OP_QUERY:  predict_path(in_start_vertex, in_end_vertex, in_path_length);
          default:   ;
        endcase
      end
    end
    outstanding <= expected_path.size();
    error_count <= mismatches;
  end

endmodule

// File: tb/fixed_length_path_search_top_tb.sv
// Testbench top for the fixed-length path search: drives graph loads, queries and vertex counts.
module fixed_length_path_search_top_tb;
  import fps_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ACTIVE_VERTICES = 8;
  localparam int PHASE_ITEMS     = 50;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [VERTEX_W-1:0] vertex;
    logic [SLOT_W-1:0]   slot;
    logic [VERTEX_W-1:0] neighbour;
    logic [DEGREE_W-1:0] degree;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic [LEN_W-1:0]    len;
  } command_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [OP_W-1:0]     in_op = '0;
  logic [VERTEX_W-1:0] in_vertex = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [VERTEX_W-1:0] in_neighbour = '0;
  logic [DEGREE_W-1:0] in_degree = '0;
  logic [VERTEX_W-1:0] in_start_vertex = '0;
  logic [VERTEX_W-1:0] in_end_vertex = '0;
  logic [LEN_W-1:0]    in_path_length = '0;
  logic                cfg_valid = 1'b0;
  logic [CFG_W-1:0]    cfg_vertex_count = '0;
  logic                busy, out_valid, out_found, out_last, cfg_ready;
  logic [VERTEX_W-1:0] out_path_vertex;
  int                  error_count, outstanding;

  bit                  slot_written [MAX_VERTICES][MAX_DEGREE];
  logic [CFG_W-1:0]    vertex_count_now = VCOUNT_RESET;
  int                  items_sent = 0;
  bit                  no_idle = 1'b0;

  fixed_length_path_search_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex(in_vertex), .in_slot(in_slot), .in_neighbour(in_neighbour),
    .in_degree(in_degree), .in_start_vertex(in_start_vertex), .in_end_vertex(in_end_vertex),
    .in_path_length(in_path_length), .out_valid(out_valid), .out_found(out_found),
    .out_path_vertex(out_path_vertex), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vertex_count(cfg_vertex_count)
  );

  fixed_length_path_search_checker path_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex(in_vertex), .in_slot(in_slot), .in_neighbour(in_neighbour),
    .in_degree(in_degree), .in_start_vertex(in_start_vertex), .in_end_vertex(in_end_vertex),
    .in_path_length(in_path_length), .out_valid(out_valid), .out_found(out_found),
    .out_path_vertex(out_path_vertex), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vertex_count(cfg_vertex_count),
    .error_count(error_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic command_t random_fields();
    command_t c;
    c.op        = OP_W'($urandom_range(0, 3));
    c.vertex    = VERTEX_W'($urandom);
    c.slot      = SLOT_W'($urandom);
    c.neighbour = VERTEX_W'($urandom);
    c.degree    = DEGREE_W'($urandom);
    c.src       = VERTEX_W'($urandom);
    c.dst       = VERTEX_W'($urandom);
    c.len       = LEN_W'($urandom);
    return c;
  endfunction

  function automatic command_t wr_nbr(input int v, input int s, input int n);
    command_t c;
    c = random_fields();
    c.op        = OP_WR_NBR;
    c.vertex    = VERTEX_W'(v);
    c.slot      = SLOT_W'(s);
    c.neighbour = VERTEX_W'(n);
    return c;
  endfunction

  function automatic command_t wr_deg(input int v, input int d);
    command_t c;
    c = random_fields();
    c.op     = OP_WR_DEG;
    c.vertex = VERTEX_W'(v);
    c.degree = DEGREE_W'(d);
    return c;
  endfunction

  function automatic command_t ask(input int s, input int e, input int l);
    command_t c;
    c = random_fields();
    c.op  = OP_QUERY;
    c.src = VERTEX_W'(s);
    c.dst = VERTEX_W'(e);
    c.len = LEN_W'(l);
    return c;
  endfunction

  // Returns at the edge where the command transfer took place.
  task automatic issue(input command_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= c.op;
    in_vertex       <= c.vertex;
    in_slot         <= c.slot;
    in_neighbour    <= c.neighbour;
    in_degree       <= c.degree;
    in_start_vertex <= c.src;
    in_end_vertex   <= c.dst;
    in_path_length  <= c.len;
    if (c.op == OP_WR_NBR) slot_written[c.vertex][c.slot] = 1'b1;
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  // The outstanding count is registered, so it is first read at the edge after the last transfer.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] val);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count_now = val;
  endtask

  // Writes a vertex's neighbour list front to back and then its degree, so no slot
  // beyond the written ones is ever searched. Low slots mostly point into the small
  // active set; high slots point at leaves, which keeps the search short.
  task automatic load_vertex();
    int v, span, s, n, r;
    v = $urandom_range(0, ACTIVE_VERTICES - 1);
    r = $urandom_range(0, 19);
    if (r < 14) span = $urandom_range(0, 4);
    else if (r < 17) span = $urandom_range(5, 15);
    else span = MAX_DEGREE;
    for (s = 0; s < span; s++) begin
      if (s >= 4) n = $urandom_range(ACTIVE_VERTICES, 31);
      else if ($urandom_range(0, 3) != 0) n = $urandom_range(0, ACTIVE_VERTICES - 1);
      else n = $urandom_range(0, 31);
      issue(wr_nbr(v, s, n));
    end
    issue(wr_deg(v, (span == MAX_DEGREE) ? $urandom_range(MAX_DEGREE, 31) : span));
  endtask

  task automatic ask_path();
    int live, hot, s, e, l;
    live = (vertex_count_now > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_now);
    if (live < 2) begin
      issue(ask($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31)));
      return;
    end
    hot = (live < ACTIVE_VERTICES) ? live : ACTIVE_VERTICES;
    s = $urandom_range(0, hot - 1);
    do begin
      e = ($urandom_range(0, 4) != 0) ? $urandom_range(0, hot - 1) : $urandom_range(0, live - 1);
    end while (e == s);
    l = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 31) : $urandom_range(2, 7);
    issue(ask(s, e, l));
  endtask

  // Any op with any fields, except that a degree never exposes an unwritten slot and
  // only the active vertices get a nonzero degree.
  task automatic noise_item();
    command_t c;
    int       lead;
    c = random_fields();
    if (c.op == OP_WR_DEG) begin
      lead = 0;
      while (lead < MAX_DEGREE && slot_written[c.vertex][lead]) lead++;
      if (c.vertex >= ACTIVE_VERTICES) c.degree = '0;
      else if (lead < MAX_DEGREE && c.degree > lead) c.degree = DEGREE_W'(lead);
    end
    issue(c);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts [10];
    command_t         odd_op;
    int               p, target, r;
    phase_counts = '{6'd8, 6'd2, 6'd5, 6'd63, 6'd0, 6'd1, 6'd32, 6'd6, 6'd40, 6'd7};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset vertex count.
    issue(ask(0, 1, 2));
    issue(wr_nbr(0, 0, 1));
    issue(wr_nbr(0, 1, 31));
    issue(wr_deg(0, 2));
    issue(wr_nbr(1, 0, 2));
    issue(wr_nbr(1, 1, 0));
    issue(wr_deg(1, 2));
    issue(wr_nbr(2, 0, 3));
    issue(wr_deg(2, 1));
    issue(ask(0, 3, 3));
    issue(ask(0, 3, 2));
    issue(ask(3, 3, 2));
    issue(ask(0, 3, 1));
    issue(ask(0, 3, 0));
    issue(ask(0, 3, 31));
    issue(ask(31, 0, 5));
    odd_op = random_fields();
    odd_op.op = OP_UNUSED;
    issue(odd_op);
    issue(wr_nbr(31, 15, 31));
    issue(wr_deg(2, 0));
    issue(ask(0, 3, 3));

    for (p = 0; p < 10; p++) begin
      wait_idle();
      set_vertex_count(phase_counts[p]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        no_idle = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 19);
        if (r < 9) load_vertex();
        else if (r < 16) ask_path();
        else noise_item();
      end
    end

    wait_idle();
    if (error_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
